[hdl/vshp_pkg.sv]
// ----------------------------------------------------------------------------
// vshp_pkg - slice header parser shared types
// Beat, result and register types, element ids, element kinds and the small
// modulo-five helpers used by the parser.
// ----------------------------------------------------------------------------
package vshp_pkg;

    localparam int unsigned FIELD_ID_W   = 4;
    localparam int unsigned VALUE_W      = 33;
    localparam int unsigned ACC_W        = 32;
    localparam int unsigned CNT_W        = 5;
    localparam int unsigned MOD5_W       = 3;
    localparam int unsigned CFG_INDEX_W  = 3;
    localparam int unsigned CFG_DATA_W   = 4;
    localparam int unsigned IN_TDATA_W   = 8;
    localparam int unsigned IN_TUSER_W   = 2;
    localparam int unsigned OUT_TDATA_W  = 40;
    localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - FIELD_ID_W - VALUE_W;
    localparam int unsigned NUM_ELEMS    = 16;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    // Register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_FRAMES_ONLY     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_NUM_BITS  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_POC_TYPE        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_POC_LSB_BITS    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DELTA_POC_ZERO  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_POC_BOTTOM      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_REDUNDANT_CNT   = 3'd6;

    // Slice header element ids, in syntax order
    localparam logic [FIELD_ID_W-1:0] ID_FIRST_MB       = 4'd0;
    localparam logic [FIELD_ID_W-1:0] ID_SLICE_TYPE     = 4'd1;
    localparam logic [FIELD_ID_W-1:0] ID_PPS_ID         = 4'd2;
    localparam logic [FIELD_ID_W-1:0] ID_FRAME_NUM      = 4'd3;
    localparam logic [FIELD_ID_W-1:0] ID_FIELD_PIC      = 4'd4;
    localparam logic [FIELD_ID_W-1:0] ID_BOTTOM_FIELD   = 4'd5;
    localparam logic [FIELD_ID_W-1:0] ID_IDR_PIC_ID     = 4'd6;
    localparam logic [FIELD_ID_W-1:0] ID_POC_LSB        = 4'd7;
    localparam logic [FIELD_ID_W-1:0] ID_DELTA_BOTTOM   = 4'd8;
    localparam logic [FIELD_ID_W-1:0] ID_DELTA_POC0     = 4'd9;
    localparam logic [FIELD_ID_W-1:0] ID_DELTA_POC1     = 4'd10;
    localparam logic [FIELD_ID_W-1:0] ID_REDUNDANT_CNT  = 4'd11;
    localparam logic [FIELD_ID_W-1:0] ID_DIRECT_SPATIAL = 4'd12;
    localparam logic [FIELD_ID_W-1:0] ID_OVERRIDE       = 4'd13;
    localparam logic [FIELD_ID_W-1:0] ID_NUM_REF_L0     = 4'd14;
    localparam logic [FIELD_ID_W-1:0] ID_NUM_REF_L1     = 4'd15;

    // Slice classes (slice type modulo five)
    localparam logic [MOD5_W-1:0] CLASS_P  = 3'd0;
    localparam logic [MOD5_W-1:0] CLASS_B  = 3'd1;
    localparam logic [MOD5_W-1:0] CLASS_SP = 3'd3;

    typedef enum logic [2:0] {
        KIND_UE     = 3'd0,
        KIND_SE     = 3'd1,
        KIND_U1     = 3'd2,
        KIND_UFRAME = 3'd3,
        KIND_UPOC   = 3'd4
    } elem_kind_t;

    typedef struct packed {
        logic       frames_only;
        logic [3:0] frame_num_bits_minus4;
        logic [1:0] poc_type;
        logic [3:0] poc_lsb_bits_minus4;
        logic       delta_poc_always_zero;
        logic       poc_bottom_present;
        logic       redundant_count_present;
    } cfg_t;

    typedef struct packed {
        logic start_req;
        logic idr;
        logic bit_in;
    } beat_t;

    typedef struct packed {
        logic [FIELD_ID_W-1:0] field_id;
        logic [VALUE_W-1:0]    value;
        logic                  last;
        logic                  error;
    } result_t;

    function automatic elem_kind_t elem_kind(input logic [FIELD_ID_W-1:0] id);
        elem_kind_t k;
        case (id)
            ID_FRAME_NUM:                                   k = KIND_UFRAME;
            ID_POC_LSB:                                     k = KIND_UPOC;
            ID_FIELD_PIC, ID_BOTTOM_FIELD,
            ID_DIRECT_SPATIAL, ID_OVERRIDE:                 k = KIND_U1;
            ID_DELTA_BOTTOM, ID_DELTA_POC0, ID_DELTA_POC1:  k = KIND_SE;
            default:                                        k = KIND_UE;
        endcase
        return k;
    endfunction

    // x mod 5 for x below 16
    function automatic logic [MOD5_W-1:0] mod5_small(input logic [3:0] x);
        logic [MOD5_W-1:0] r;
        case (x)
            4'd0, 4'd5, 4'd10, 4'd15: r = 3'd0;
            4'd1, 4'd6, 4'd11:        r = 3'd1;
            4'd2, 4'd7, 4'd12:        r = 3'd2;
            4'd3, 4'd8, 4'd13:        r = 3'd3;
            default:                  r = 3'd4;
        endcase
        return r;
    endfunction

    // (2r + b) mod 5
    function automatic logic [MOD5_W-1:0] dbl_mod5(input logic [MOD5_W-1:0] r,
                                                   input logic b);
        return mod5_small({r, b});
    endfunction

endpackage

[hdl/vshp_front.sv]
// ----------------------------------------------------------------------------
// vshp_front - input side of the slice header parser
// Accepts bitstream beats, unpacks them and holds them in a short queue
// for the decoder.
// ----------------------------------------------------------------------------
module vshp_front #(
    parameter int unsigned QUEUE_DEPTH = vshp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [vshp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [0] bit_in
    input  logic [vshp_pkg::IN_TUSER_W-1:0]  s_axis_tuser,   // [0] start_req, [1] idr
    output logic                             q_valid,
    output vshp_pkg::beat_t                  q_beat,
    input  logic                             q_pop
);
    import vshp_pkg::*;

    localparam int unsigned PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned COUNT_W = $clog2(QUEUE_DEPTH + 1);

    beat_t              queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               push;
    logic               pop;
    beat_t              in_beat;

    assign in_beat.start_req = s_axis_tuser[0];
    assign in_beat.idr       = s_axis_tuser[1];
    assign in_beat.bit_in    = s_axis_tdata[0];

    assign s_axis_tready = (count_reg != COUNT_W'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != '0);
    assign pop           = q_pop && q_valid;
    assign q_beat        = queue_reg[rd_ptr_reg];

    // Wrap pointers at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + COUNT_W'(push) - COUNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= in_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/vshp_back.sv]
// ----------------------------------------------------------------------------
// vshp_back - slice header element decoder
// Takes one queued bit per cycle while out_free is high, runs the Exp-Golomb
// and fixed-width reads and picks the next present element.
// ----------------------------------------------------------------------------
module vshp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  vshp_pkg::cfg_t    cfg,
    input  logic              q_valid,
    input  vshp_pkg::beat_t   q_beat,
    output logic              q_pop,
    input  logic              out_free,
    output logic              res_valid,
    output vshp_pkg::result_t res
);
    import vshp_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_PREFIX = 4'b0010,
        PH_SUFFIX = 4'b0100,
        PH_FIXED  = 4'b1000
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [FIELD_ID_W-1:0] id_reg, id_next;
    logic [CNT_W-1:0]      zc_reg, zc_next;
    logic [CNT_W-1:0]      bl_reg, bl_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [MOD5_W-1:0]     p_reg, p_next;      // 2^zero_count mod 5
    logic [MOD5_W-1:0]     r_reg, r_next;      // suffix mod 5
    logic [MOD5_W-1:0]     cls_reg, cls_next;
    logic                  fpic_reg, fpic_next;
    logic                  ovr_reg, ovr_next;
    logic                  idr_reg, idr_next;

    phase_t                e_phase;
    logic [FIELD_ID_W-1:0] e_id;
    logic [CNT_W-1:0]      e_zc, e_bl;
    logic [ACC_W-1:0]      e_acc;
    logic [MOD5_W-1:0]     e_p, e_r, e_cls;
    logic                  e_fpic, e_ovr, e_idr;
    logic                  fresh;
    elem_kind_t            kind, nkind;
    logic [ACC_W-1:0]      acc_sh, acc_src, sv;
    logic [MOD5_W-1:0]     r_sh, r_src, code_mod5;
    logic [VALUE_W-1:0]    mag;
    logic [VALUE_W-1:0]    code_val;
    logic                  done;
    logic                  err;
    logic                  pred;
    logic                  d0;
    logic [NUM_ELEMS-1:0]  present;
    logic                  found;
    logic [FIELD_ID_W-1:0] nid;

    assign q_pop = q_valid && out_free;
    assign fresh = q_pop && q_beat.start_req;

    // Start of a header overrides the held state
    always_comb
    begin
        e_phase = fresh ? PH_PREFIX   : phase_reg;
        e_id    = fresh ? ID_FIRST_MB : id_reg;
        e_zc    = fresh ? '0          : zc_reg;
        e_bl    = fresh ? '0          : bl_reg;
        e_acc   = fresh ? '0          : acc_reg;
        e_p     = fresh ? 3'd1        : p_reg;
        e_r     = fresh ? '0          : r_reg;
        e_cls   = fresh ? '0          : cls_reg;
        e_fpic  = fresh ? 1'b0        : fpic_reg;
        e_ovr   = fresh ? 1'b0        : ovr_reg;
        e_idr   = fresh ? q_beat.idr  : idr_reg;
    end

    assign kind   = elem_kind(e_id);
    assign acc_sh = {e_acc[ACC_W-2:0], q_beat.bit_in};
    assign r_sh   = dbl_mod5(e_r, q_beat.bit_in);

    // Exp-Golomb value: code = 2^zc - 1 + suffix
    assign acc_src   = (e_phase == PH_SUFFIX) ? acc_sh : '0;
    assign r_src     = (e_phase == PH_SUFFIX) ? r_sh : '0;
    assign sv        = (ACC_W'(1) << e_zc) | acc_src;
    assign mag       = {2'b00, sv[ACC_W-1:1]};
    assign code_mod5 = mod5_small(4'({1'b0, e_p}) + 4'({1'b0, r_src}) + 4'd4);

    always_comb
    begin
        case (kind)
            KIND_UE:
            begin
                code_val = {1'b0, sv - ACC_W'(1)};
            end
            KIND_SE:
            begin
                code_val = acc_src[0] ? (~mag + VALUE_W'(1)) : mag;
            end
            default:
            begin
                code_val = {1'b0, acc_sh};
            end
        endcase
    end

    always_comb
    begin
        phase_next = e_phase;
        id_next    = e_id;
        zc_next    = e_zc;
        bl_next    = e_bl;
        acc_next   = e_acc;
        p_next     = e_p;
        r_next     = e_r;
        cls_next   = e_cls;
        fpic_next  = e_fpic;
        ovr_next   = e_ovr;
        idr_next   = e_idr;
        done       = 1'b0;
        err        = 1'b0;

        if (q_pop)
        begin
            case (e_phase)
                PH_FIXED:
                begin
                    if (e_bl <= CNT_W'(1))
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        bl_next  = e_bl - 1'b1;
                        acc_next = acc_sh;
                    end
                end
                PH_PREFIX:
                begin
                    if (!q_beat.bit_in)
                    begin
                        if (e_zc == '1)
                        begin
                            err        = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            zc_next = e_zc + 1'b1;
                            p_next  = dbl_mod5(e_p, 1'b0);
                        end
                    end
                    else if (e_zc == '0)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_SUFFIX;
                        bl_next    = e_zc;
                        acc_next   = '0;
                        r_next     = '0;
                    end
                end
                PH_SUFFIX:
                begin
                    if (e_bl <= CNT_W'(1))
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        bl_next  = e_bl - 1'b1;
                        acc_next = acc_sh;
                        r_next   = r_sh;
                    end
                end
                default:
                begin
                end
            endcase

            if (done)
            begin
                case (e_id)
                    ID_SLICE_TYPE: cls_next  = code_mod5;
                    ID_FIELD_PIC:  fpic_next = q_beat.bit_in;
                    ID_OVERRIDE:   ovr_next  = q_beat.bit_in;
                    default:
                    begin
                    end
                endcase
            end
        end

        // Presence of each element under the updated header state
        pred = (cls_next == CLASS_P) || (cls_next == CLASS_B) || (cls_next == CLASS_SP);
        d0   = (cfg.poc_type == 2'd1) && !cfg.delta_poc_always_zero;
        present = '0;
        present[ID_FIRST_MB]       = 1'b1;
        present[ID_SLICE_TYPE]     = 1'b1;
        present[ID_PPS_ID]         = 1'b1;
        present[ID_FRAME_NUM]      = 1'b1;
        present[ID_FIELD_PIC]      = !cfg.frames_only;
        present[ID_BOTTOM_FIELD]   = !cfg.frames_only && fpic_next;
        present[ID_IDR_PIC_ID]     = idr_next;
        present[ID_POC_LSB]        = (cfg.poc_type == 2'd0);
        present[ID_DELTA_BOTTOM]   = (cfg.poc_type == 2'd0) && cfg.poc_bottom_present
                                     && !fpic_next;
        present[ID_DELTA_POC0]     = d0;
        present[ID_DELTA_POC1]     = d0 && cfg.poc_bottom_present && !fpic_next;
        present[ID_REDUNDANT_CNT]  = cfg.redundant_count_present;
        present[ID_DIRECT_SPATIAL] = (cls_next == CLASS_B);
        present[ID_OVERRIDE]       = pred;
        present[ID_NUM_REF_L0]     = pred && ovr_next;
        present[ID_NUM_REF_L1]     = pred && ovr_next && (cls_next == CLASS_B);

        found = 1'b0;
        nid   = '0;
        for (int j = 0; j < NUM_ELEMS; j++)
        begin
            if (!found && (FIELD_ID_W'(j) > e_id) && present[j])
            begin
                found = 1'b1;
                nid   = FIELD_ID_W'(j);
            end
        end
        nkind = elem_kind(nid);

        if (done)
        begin
            if (found)
            begin
                // Open the next element
                id_next  = nid;
                zc_next  = '0;
                acc_next = '0;
                p_next   = 3'd1;
                r_next   = '0;
                case (nkind)
                    KIND_U1:
                    begin
                        phase_next = PH_FIXED;
                        bl_next    = CNT_W'(1);
                    end
                    KIND_UFRAME:
                    begin
                        phase_next = PH_FIXED;
                        bl_next    = CNT_W'(cfg.frame_num_bits_minus4) + CNT_W'(4);
                    end
                    KIND_UPOC:
                    begin
                        phase_next = PH_FIXED;
                        bl_next    = CNT_W'(cfg.poc_lsb_bits_minus4) + CNT_W'(4);
                    end
                    default:
                    begin
                        phase_next = PH_PREFIX;
                        bl_next    = '0;
                    end
                endcase
            end
            else
            begin
                phase_next = PH_IDLE;
            end
        end
    end

    assign res_valid    = done || err;
    assign res.field_id = e_id;
    assign res.value    = err ? '0 : code_val;
    assign res.last     = err || !found;
    assign res.error    = err;

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        zc_reg   <= zc_next;
        bl_reg   <= bl_next;
        acc_reg  <= acc_next;
        p_reg    <= p_next;
        r_reg    <= r_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cls_reg   <= '0;
            fpic_reg  <= 1'b0;
            ovr_reg   <= 1'b0;
            idr_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cls_reg   <= cls_next;
            fpic_reg  <= fpic_next;
            ovr_reg   <= ovr_next;
            idr_reg   <= idr_next;
        end
    end

endmodule

[hdl/video_slice_header_parser.sv]
// Output path: the beat that completes an element is written to the queue,
//   then decoded into the output register that drives the master side.
// Throughput: one bitstream beat per cycle, set by the single-bit decode step,
//   while the output register can take a result.
// Reset: rst_n clears the queue, the output register and the parser (idle,
//   waiting for start_req); registers return to frames_only = 1, others 0.
// ----------------------------------------------------------------------------
// video_slice_header_parser - leading H.264 slice header element parser
// Decodes ue, se and fixed-width slice header elements from a serial bit
// stream and emits each element with its id and value.
// ----------------------------------------------------------------------------
module video_slice_header_parser #(
    parameter int unsigned QUEUE_DEPTH = vshp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Bitstream input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [vshp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [0] bit_in, rest zero
    input  logic [vshp_pkg::IN_TUSER_W-1:0]   s_axis_tuser,  // [0] start_req, [1] idr
    // Decoded elements
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [vshp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [3:0] field_id,
                                                             // [36:4] value, rest zero
    output logic                              m_axis_tlast,  // last element of header
    output logic                              m_axis_tuser,  // [0] error
    // Register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vshp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [vshp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import vshp_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;
    logic    q_valid;
    beat_t   q_beat;
    logic    q_pop;
    logic    out_free;
    logic    res_valid;
    result_t res;

    // ------------------------------------------------------------------
    // Register file: always ready, writes take effect on the next cycle
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FRAMES_ONLY:    cfg_next.frames_only             = cfg_data[0];
                REG_FRAME_NUM_BITS: cfg_next.frame_num_bits_minus4   = cfg_data;
                REG_POC_TYPE:       cfg_next.poc_type                = cfg_data[1:0];
                REG_POC_LSB_BITS:   cfg_next.poc_lsb_bits_minus4     = cfg_data;
                REG_DELTA_POC_ZERO: cfg_next.delta_poc_always_zero   = cfg_data[0];
                REG_POC_BOTTOM:     cfg_next.poc_bottom_present      = cfg_data[0];
                REG_REDUNDANT_CNT:  cfg_next.redundant_count_present = cfg_data[0];
                default:
                begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg                         <= '0;
            cfg_reg.frames_only             <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Front: accept beats into the queue
    // ------------------------------------------------------------------
    vshp_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_beat        (q_beat),
        .q_pop         (q_pop)
    );

    // ------------------------------------------------------------------
    // Back: decode one bit per cycle whenever the output register can
    // take a result in the same cycle
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || m_axis_tready;

    vshp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_beat    (q_beat),
        .q_pop     (q_pop),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    // ------------------------------------------------------------------
    // Output register: load a new result when free, hold while stalled
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_reg.value, out_reg.field_id};
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tuser  = out_reg.error;

endmodule

[hdl/vshp_checker.sv]
// ----------------------------------------------------------------------------
// vshp_checker - port-level checks for the slice header parser
// Watches the master side for stall stability, error-beat shape and clear padding.
// ----------------------------------------------------------------------------
module vshp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [vshp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input logic [vshp_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [vshp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                              m_axis_tlast,
    input logic                              m_axis_tuser,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [vshp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input logic [vshp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import vshp_pkg::*;

    // A stalled beat holds its payload
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
             && $stable(m_axis_tuser));
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("output beat changed while stalled");

    // An error ends the header
    property p_err_last;
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast;
    endproperty
    a_err_last: assert property (p_err_last)
        else $error("error beat not marked last");

    // An error beat carries a zero value
    property p_err_zero;
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (m_axis_tdata[FIELD_ID_W +: VALUE_W] == '0);
    endproperty
    a_err_zero: assert property (p_err_zero)
        else $error("error beat with non-zero value");

    // Padding above the value stays clear
    property p_pad_zero;
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:FIELD_ID_W+VALUE_W] == '0);
    endproperty
    a_pad_zero: assert property (p_pad_zero)
        else $error("output padding bits set");

endmodule

bind video_slice_header_parser vshp_checker u_vshp_checker (.*);

[verif/video_slice_header_parser_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// video_slice_header_parser_checker - element predictor and scoreboard
// Watches the register channel, the bitstream channel and the element
// channel. Runs its own parser on every accepted bit and compares each
// element that leaves the block with the oldest predicted one.
// ----------------------------------------------------------------------------
module video_slice_header_parser_checker
    import vshp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   m_axis_tlast,
    input  logic                   m_axis_tuser,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int unsigned            mismatches,
    output int unsigned            pending,
    output int unsigned            beats_seen,
    output int unsigned            elements_seen,
    output int unsigned            overlong_seen
);

    localparam logic [4:0] ELEM_IDLE = 5'd16;

    cfg_t        regs;
    logic [4:0]  elem;
    logic        in_suffix;
    logic [5:0]  zeros;
    logic [5:0]  remain;
    logic [31:0] acc;
    logic [2:0]  sclass;
    logic        field_pic;
    logic        override_on;
    logic        idr_held;

    result_t     expected_elems[$];

    function automatic elem_kind_t kind_of(input logic [3:0] id);
        case (id)
            ID_FRAME_NUM:                                  return KIND_UFRAME;
            ID_POC_LSB:                                    return KIND_UPOC;
            ID_FIELD_PIC, ID_BOTTOM_FIELD,
            ID_DIRECT_SPATIAL, ID_OVERRIDE:                return KIND_U1;
            ID_DELTA_BOTTOM, ID_DELTA_POC0, ID_DELTA_POC1: return KIND_SE;
            default:                                       return KIND_UE;
        endcase
    endfunction

    function automatic logic present(input logic [4:0] id);
        logic inter;
        logic deltas;
        inter  = (sclass == CLASS_P) || (sclass == CLASS_B) || (sclass == CLASS_SP);
        deltas = (regs.poc_type == 2'd1) && !regs.delta_poc_always_zero;
        case (id[3:0])
            ID_FIELD_PIC:      return !regs.frames_only;
            ID_BOTTOM_FIELD:   return !regs.frames_only && field_pic;
            ID_IDR_PIC_ID:     return idr_held;
            ID_POC_LSB:        return regs.poc_type == 2'd0;
            ID_DELTA_BOTTOM:   return (regs.poc_type == 2'd0) && regs.poc_bottom_present
                                      && !field_pic;
            ID_DELTA_POC0:     return deltas;
            ID_DELTA_POC1:     return deltas && regs.poc_bottom_present && !field_pic;
            ID_REDUNDANT_CNT:  return regs.redundant_count_present;
            ID_DIRECT_SPATIAL: return sclass == CLASS_B;
            ID_OVERRIDE:       return inter;
            ID_NUM_REF_L0:     return inter && override_on;
            ID_NUM_REF_L1:     return inter && override_on && (sclass == CLASS_B);
            default:           return 1'b1;
        endcase
    endfunction

    task automatic open_elem(input logic [4:0] id);
        elem      = id;
        in_suffix = 1'b0;
        zeros     = '0;
        acc       = '0;
        case (kind_of(id[3:0]))
            KIND_U1:     remain = 6'd1;
            KIND_UFRAME: remain = {2'd0, regs.frame_num_bits_minus4} + 6'd4;
            KIND_UPOC:   remain = {2'd0, regs.poc_lsb_bits_minus4} + 6'd4;
            default:     remain = '0;
        endcase
    endtask

    task automatic close_header();
        elem      = ELEM_IDLE;
        in_suffix = 1'b0;
        zeros     = '0;
        remain    = '0;
        acc       = '0;
    endtask

    // Advance the parser by one bit; flag and return the element it finishes
    task automatic parse_bit(input beat_t b, output logic got, output result_t r);
        elem_kind_t  k;
        logic        done;
        logic [32:0] code;
        logic [4:0]  nxt;
        got  = 1'b0;
        r    = '0;
        done = 1'b0;
        code = '0;
        if (b.start_req)
        begin
            idr_held    = b.idr;
            sclass      = '0;
            field_pic   = 1'b0;
            override_on = 1'b0;
            open_elem(5'd0);
        end
        if (elem == ELEM_IDLE)
        begin
            return;
        end
        k = kind_of(elem[3:0]);
        if (k == KIND_U1 || k == KIND_UFRAME || k == KIND_UPOC)
        begin
            acc = {acc[30:0], b.bit_in};
            if (remain != 0)
            begin
                remain--;
            end
            if (remain == 0)
            begin
                done = 1'b1;
                code = {1'b0, acc};
            end
        end
        else if (!in_suffix)
        begin
            if (!b.bit_in)
            begin
                zeros++;
                // Prefix too long: report it on the current element and stop
                if (zeros > 6'd31)
                begin
                    got        = 1'b1;
                    r.field_id = elem[3:0];
                    r.last     = 1'b1;
                    r.error    = 1'b1;
                    close_header();
                    return;
                end
            end
            else if (zeros == 0)
            begin
                done = 1'b1;
            end
            else
            begin
                in_suffix = 1'b1;
                remain    = zeros;
                acc       = '0;
            end
        end
        else
        begin
            acc = {acc[30:0], b.bit_in};
            if (remain != 0)
            begin
                remain--;
            end
            if (remain == 0)
            begin
                done = 1'b1;
                code = ((33'd1 << zeros[4:0]) - 33'd1) + {1'b0, acc};
            end
        end
        if (!done)
        begin
            return;
        end

        if (k == KIND_SE)
        begin
            r.value = code[0] ? (code + 33'd1) >> 1 : 33'd0 - (code >> 1);
        end
        else
        begin
            r.value = code;
        end
        if (elem == ID_SLICE_TYPE)
        begin
            sclass = 3'(code % 33'd5);
        end
        else if (elem == ID_FIELD_PIC)
        begin
            field_pic = code[0];
        end
        else if (elem == ID_OVERRIDE)
        begin
            override_on = code[0];
        end

        nxt = elem + 5'd1;
        while (nxt < ELEM_IDLE && !present(nxt))
        begin
            nxt++;
        end
        got        = 1'b1;
        r.field_id = elem[3:0];
        r.last     = (nxt == ELEM_IDLE);
        r.error    = 1'b0;
        if (nxt == ELEM_IDLE)
        begin
            close_header();
        end
        else
        begin
            open_elem(nxt);
        end
    endtask

    task automatic compare_element(input result_t seen);
        result_t want;
        if (expected_elems.size() == 0)
        begin
            $error("unexpected element: field_id %0d value %0h last %0b error %0b",
                   seen.field_id, seen.value, seen.last, seen.error);
            mismatches++;
            return;
        end
        want = expected_elems.pop_front();
        if (seen.field_id !== want.field_id)
        begin
            $error("field_id mismatch: expected %0d, actual %0d", want.field_id,
                   seen.field_id);
            mismatches++;
        end
        if (seen.value !== want.value)
        begin
            $error("value mismatch: expected %0h, actual %0h", want.value, seen.value);
            mismatches++;
        end
        if (seen.last !== want.last)
        begin
            $error("last mismatch: expected %0b, actual %0b", want.last, seen.last);
            mismatches++;
        end
        if (seen.error !== want.error)
        begin
            $error("error mismatch: expected %0b, actual %0b", want.error, seen.error);
            mismatches++;
        end
        if (want.error)
        begin
            overlong_seen++;
        end
        elements_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        beat_t   b;
        result_t r;
        logic    got;
        if (!rst_n)
        begin
            regs             = '0;
            regs.frames_only = 1'b1;
            sclass           = '0;
            field_pic        = 1'b0;
            override_on      = 1'b0;
            idr_held         = 1'b0;
            close_header();
            expected_elems.delete();
            mismatches    = 0;
            pending       = 0;
            beats_seen    = 0;
            elements_seen = 0;
            overlong_seen = 0;
        end
        else
        begin
            // Check the outgoing beat first: it can never stem from this edge's input
            if (m_axis_tvalid && m_axis_tready)
            begin
                r.field_id = m_axis_tdata[FIELD_ID_W-1:0];
                r.value    = m_axis_tdata[FIELD_ID_W+VALUE_W-1:FIELD_ID_W];
                r.last     = m_axis_tlast;
                r.error    = m_axis_tuser;
                compare_element(r);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FRAMES_ONLY:    regs.frames_only             = cfg_data[0];
                    REG_FRAME_NUM_BITS: regs.frame_num_bits_minus4   = cfg_data;
                    REG_POC_TYPE:       regs.poc_type                = cfg_data[1:0];
                    REG_POC_LSB_BITS:   regs.poc_lsb_bits_minus4     = cfg_data;
                    REG_DELTA_POC_ZERO: regs.delta_poc_always_zero   = cfg_data[0];
                    REG_POC_BOTTOM:     regs.poc_bottom_present      = cfg_data[0];
                    REG_REDUNDANT_CNT:  regs.redundant_count_present = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                b.start_req = s_axis_tuser[0];
                b.idr       = s_axis_tuser[1];
                b.bit_in    = s_axis_tdata[0];
                parse_bit(b, got, r);
                if (got)
                begin
                    expected_elems.push_back(r);
                end
                beats_seen++;
            end
            pending = expected_elems.size();
        end
    end

endmodule

[verif/video_slice_header_parser_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// video_slice_header_parser_tb - slice header parser testbench
// Encodes slice headers into serial bitstreams (well-formed headers with
// random content, overlong prefixes, cut-off headers and loose bits) and
// streams them through the parser under several register settings and
// idling patterns. The checker beside the block predicts every element.
// ----------------------------------------------------------------------------
module video_slice_header_parser_tb;

    import vshp_pkg::*;

    // Value styles for the header encoder
    localparam int VAL_RAND = 0;
    localparam int VAL_MIN  = 1;
    localparam int VAL_MAX  = 2;
    // Markers for "no overlong prefix" and "no cut"
    localparam int NO_LONG  = -1;
    localparam int NO_CUT   = 0;

    localparam int NUM_PHASES  = 12;
    localparam int PHASE_BEATS = 75;
    localparam int HOLD_PHASE  = 4;
    localparam int DRAIN_WAIT  = 8;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned beats_seen;
    int unsigned elements_seen;
    int unsigned overlong_seen;

    // Stimulus side state
    cfg_t  cfg;              // register values as last written
    beat_t stream[$];        // bits waiting to be sent
    int    s_idle_pct;
    int    m_stall_pct;
    int    recv_hold;        // output hold-off still to run, in cycles
    int    sent;
    int    settings_used;

    video_slice_header_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    video_slice_header_parser_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending),
        .beats_seen    (beats_seen),
        .elements_seen (elements_seen),
        .overlong_seen (overlong_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Hard stop in case the block hangs
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Element receiver: random stalls, or a solid hold-off while recv_hold runs down
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (recv_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                recv_hold--;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= m_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Bitstream encoding
    // ------------------------------------------------------------------

    task automatic push_bit(input logic b);
        beat_t t;
        t.start_req = 1'b0;
        t.idr       = 1'($urandom_range(1));  // idr is don't-care away from start
        t.bit_in    = b;
        stream.push_back(t);
    endtask

    task automatic push_bits(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
        begin
            push_bit(v[i]);
        end
    endtask

    task automatic push_zeros(input int n);
        repeat (n)
        begin
            push_bit(1'b0);
        end
    endtask

    // Exp-Golomb code word for v: (bit length of v + 1, less one) zeros, then v + 1
    task automatic push_ue(input logic [31:0] v);
        logic [32:0] c;
        int          msb;
        c   = {1'b0, v} + 33'd1;
        msb = 32;
        while (!c[msb])
        begin
            msb--;
        end
        push_zeros(msb);
        for (int i = msb; i >= 0; i--)
        begin
            push_bit(c[i]);
        end
    endtask

    // Mostly short codes, now and then the full 32-bit range
    function automatic logic [31:0] rand_code();
        int r;
        r = $urandom_range(99);
        if (r < 55)
        begin
            return $urandom_range(6);
        end
        if (r < 85)
        begin
            return $urandom_range(255);
        end
        if (r < 96)
        begin
            return $urandom_range(65535);
        end
        return $urandom_range(32'hFFFF_FFFE);
    endfunction

    function automatic logic [31:0] pick_code(input int vmode);
        case (vmode)
            VAL_MIN: return 32'd0;
            // Largest code word (31 zeros); odd/even neighbours give both se extremes
            VAL_MAX: return 32'hFFFF_FFFE - $urandom_range(1);
            default: return rand_code();
        endcase
    endfunction

    function automatic logic [31:0] fix_val(input int vmode, input int n);
        logic [31:0] m;
        m = (32'd1 << n) - 32'd1;
        case (vmode)
            VAL_MIN: return 32'd0;
            VAL_MAX: return m;
            default: return $urandom & m;
        endcase
    endfunction

    // Exp-Golomb element, or an overlong prefix if this is the element to break
    task automatic put_ue(input int id, input int vmode, input int long_at);
        if (id == long_at)
        begin
            push_zeros(32);
        end
        else
        begin
            push_ue(pick_code(vmode));
        end
    endtask

    // Encode one slice header against the current registers. Bits following an
    // overlong prefix are ignored by the parser; cut > 0 keeps only that many
    // bits, so the next header restarts the parser mid-way.
    task automatic build_header(input int vmode, input int long_at, input int cut);
        int          first;
        int          fn_w;
        int          lsb_w;
        logic        idr;
        logic        fpic;
        logic        ovr;
        logic        inter;
        logic [31:0] st;
        logic [31:0] tmp;
        logic [2:0]  cls;
        beat_t       head;
        first = stream.size();
        fn_w  = int'(cfg.frame_num_bits_minus4) + 4;
        lsb_w = int'(cfg.poc_lsb_bits_minus4) + 4;
        idr   = 1'($urandom_range(1));
        case (vmode)
            VAL_MIN: st = 32'd0;
            VAL_MAX: st = $urandom_range(1) ? 32'd6 : 32'd1;
            default: st = ($urandom_range(9) < 9) ? $urandom_range(9) : rand_code();
        endcase
        cls = 3'(st % 32'd5);

        put_ue(ID_FIRST_MB, vmode, long_at);
        if (long_at == ID_SLICE_TYPE)
        begin
            push_zeros(32);
        end
        else
        begin
            push_ue(st);
        end
        put_ue(ID_PPS_ID, vmode, long_at);
        push_bits(fix_val(vmode, fn_w), fn_w);
        fpic = 1'b0;
        if (!cfg.frames_only)
        begin
            tmp  = fix_val(vmode, 1);
            fpic = tmp[0];
            push_bit(fpic);
            if (fpic)
            begin
                tmp = fix_val(vmode, 1);
                push_bit(tmp[0]);
            end
        end
        if (idr)
        begin
            put_ue(ID_IDR_PIC_ID, vmode, long_at);
        end
        if (cfg.poc_type == 2'd0)
        begin
            push_bits(fix_val(vmode, lsb_w), lsb_w);
            if (cfg.poc_bottom_present && !fpic)
            begin
                put_ue(ID_DELTA_BOTTOM, vmode, long_at);
            end
        end
        if (cfg.poc_type == 2'd1 && !cfg.delta_poc_always_zero)
        begin
            put_ue(ID_DELTA_POC0, vmode, long_at);
            if (cfg.poc_bottom_present && !fpic)
            begin
                put_ue(ID_DELTA_POC1, vmode, long_at);
            end
        end
        if (cfg.redundant_count_present)
        begin
            put_ue(ID_REDUNDANT_CNT, vmode, long_at);
        end
        if (cls == CLASS_B)
        begin
            tmp = fix_val(vmode, 1);
            push_bit(tmp[0]);
        end
        inter = (cls == CLASS_P) || (cls == CLASS_B) || (cls == CLASS_SP);
        if (inter)
        begin
            tmp = fix_val(vmode, 1);
            ovr = tmp[0];
            push_bit(ovr);
            if (ovr)
            begin
                put_ue(ID_NUM_REF_L0, vmode, long_at);
                if (cls == CLASS_B)
                begin
                    put_ue(ID_NUM_REF_L1, vmode, long_at);
                end
            end
        end

        head           = stream[first];
        head.start_req = 1'b1;
        head.idr       = idr;
        stream[first]  = head;
        if (cut > 0)
        begin
            while (stream.size() > first + cut)
            begin
                void'(stream.pop_back());
            end
        end
    endtask

    // Loose random bits; with a start they form a garbled header
    task automatic push_noise(input logic with_start, input int n);
        int    first;
        beat_t head;
        first = stream.size();
        repeat (n)
        begin
            push_bit(1'($urandom_range(1)));
        end
        if (with_start)
        begin
            head           = stream[first];
            head.start_req = 1'b1;
            stream[first]  = head;
        end
    endtask

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Offer one bit; valid stays high afterwards so headers run back to back
    task automatic send_beat(input beat_t b);
        @(negedge clk);
        while ($urandom_range(99) < s_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, b.bit_in};
        s_axis_tuser  <= {b.idr, b.start_req};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        sent++;
    endtask

    task automatic flush_stream(input int upto);
        for (int i = 0; i < upto; i++)
        begin
            send_beat(stream[i]);
        end
        repeat (upto)
        begin
            void'(stream.pop_front());
        end
    endtask

    // Drop valid and hold until every predicted element has left the block
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT)
        begin
            @(posedge clk);
        end
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(input cfg_t c);
        cfg_write(REG_FRAMES_ONLY,    {3'd0, c.frames_only});
        cfg_write(REG_FRAME_NUM_BITS, c.frame_num_bits_minus4);
        cfg_write(REG_POC_TYPE,       {2'd0, c.poc_type});
        cfg_write(REG_POC_LSB_BITS,   c.poc_lsb_bits_minus4);
        cfg_write(REG_DELTA_POC_ZERO, {3'd0, c.delta_poc_always_zero});
        cfg_write(REG_POC_BOTTOM,     {3'd0, c.poc_bottom_present});
        cfg_write(REG_REDUNDANT_CNT,  {3'd0, c.redundant_count_present});
        cfg = c;
        settings_used++;
    endtask

    function automatic cfg_t rand_regs();
        cfg_t c;
        c.frames_only             = 1'($urandom_range(1));
        c.frame_num_bits_minus4   = 4'($urandom_range(12));
        // Favour the order count types that carry elements; keep 2 and 3 in play
        c.poc_type                = ($urandom_range(9) < 8) ? 2'($urandom_range(1))
                                                            : 2'(2 + $urandom_range(1));
        c.poc_lsb_bits_minus4     = 4'($urandom_range(12));
        c.delta_poc_always_zero   = 1'($urandom_range(1));
        c.poc_bottom_present      = 1'($urandom_range(1));
        c.redundant_count_present = 1'($urandom_range(1));
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        cfg_t c;
        int   r;
        int   vmode;
        int   target;
        int   long_ids[10];
        long_ids = '{ID_FIRST_MB, ID_SLICE_TYPE, ID_PPS_ID, ID_IDR_PIC_ID,
                     ID_DELTA_BOTTOM, ID_DELTA_POC0, ID_DELTA_POC1,
                     ID_REDUNDANT_CNT, ID_NUM_REF_L0, ID_NUM_REF_L1};

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_idle_pct    = 0;
        m_stall_pct   = 0;
        recv_hold     = 0;
        sent          = 0;
        settings_used = 0;
        cfg             = '0;
        cfg.frames_only = 1'b1;

        repeat (5)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset registers, loose bits while idle, value extremes,
        // an overlong first element, and a header abandoned by a restart
        push_noise(1'b0, 3);
        build_header(VAL_MAX, NO_LONG, NO_CUT);
        build_header(VAL_MIN, NO_LONG, NO_CUT);
        build_header(VAL_RAND, ID_FIRST_MB, NO_CUT);
        build_header(VAL_RAND, NO_LONG, 9);
        build_header(VAL_MIN, NO_LONG, NO_CUT);
        flush_stream(stream.size());
        wait_drained();

        // Field pictures allowed, type-one deltas, widest fields, redundant count
        c = '{frames_only: 1'b0, frame_num_bits_minus4: 4'd12, poc_type: 2'd1,
              poc_lsb_bits_minus4: 4'd12, delta_poc_always_zero: 1'b0,
              poc_bottom_present: 1'b1, redundant_count_present: 1'b1};
        program_regs(c);
        build_header(VAL_MAX, NO_LONG, NO_CUT);
        build_header(VAL_MIN, NO_LONG, NO_CUT);
        build_header(VAL_RAND, ID_DELTA_POC0, NO_CUT);
        flush_stream(stream.size());
        wait_drained();

        // Order count type zero with bottom delta; field and frame pictures
        c.poc_type              = 2'd0;
        c.delta_poc_always_zero = 1'b1;
        c.redundant_count_present = 1'b0;
        program_regs(c);
        build_header(VAL_MAX, NO_LONG, NO_CUT);
        build_header(VAL_MIN, NO_LONG, NO_CUT);
        flush_stream(stream.size());

        // Change the registers half-way through a header
        build_header(VAL_RAND, NO_LONG, NO_CUT);
        flush_stream(stream.size() / 2);
        wait_drained();
        program_regs(rand_regs());
        flush_stream(stream.size());
        wait_drained();

        // Order count type with no order count elements
        c.poc_type = 2'd3;
        program_regs(c);
        build_header(VAL_RAND, NO_LONG, NO_CUT);
        build_header(VAL_RAND, NO_LONG, NO_CUT);
        flush_stream(stream.size());

        // Random phases: each with its own registers and idling pattern
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            if (p == 0)
            begin
                c             = '0;
                c.frames_only = 1'b1;
            end
            else if (p == 1)
            begin
                c = '{frames_only: 1'b1, frame_num_bits_minus4: 4'd12, poc_type: 2'd3,
                      poc_lsb_bits_minus4: 4'd12, delta_poc_always_zero: 1'b1,
                      poc_bottom_present: 1'b1, redundant_count_present: 1'b1};
            end
            else
            begin
                c = rand_regs();
            end
            program_regs(c);
            case (p % 4)
                0:
                begin
                    s_idle_pct  = 0;
                    m_stall_pct = 0;
                end
                1:
                begin
                    s_idle_pct  = 66;
                    m_stall_pct = 0;
                end
                2:
                begin
                    s_idle_pct  = 0;
                    m_stall_pct = 66;
                end
                default:
                begin
                    s_idle_pct  = 7;
                    m_stall_pct = 7;
                end
            endcase
            // Block the element channel for a long stretch so the output register stays
            // full, the input queue fills and the bitstream side backs up
            if (p == HOLD_PHASE)
            begin
                recv_hold = 300;
            end

            target = sent + PHASE_BEATS;
            while (sent < target)
            begin
                r     = $urandom_range(99);
                vmode = $urandom_range(99);
                vmode = (vmode < 5) ? VAL_MIN : (vmode < 15) ? VAL_MAX : VAL_RAND;
                if (r < 78)
                begin
                    build_header(vmode, NO_LONG, NO_CUT);
                end
                else if (r < 86)
                begin
                    build_header(VAL_RAND, long_ids[$urandom_range(9)], NO_CUT);
                end
                else if (r < 94)
                begin
                    build_header(VAL_RAND, NO_LONG, $urandom_range(1, 30));
                end
                else
                begin
                    push_noise(r >= 97, $urandom_range(1, 12));
                end
                flush_stream(stream.size());
            end
        end

        // Sender done: hold until every element has come out
        wait_drained();

        $display("Streamed %0d bitstream beats, checked %0d elements (%0d overlong prefixes)",
                 beats_seen, elements_seen, overlong_seen);
        $display("over %0d register settings, four idling patterns and one long hold-off",
                 settings_used);
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
